[design/srfp_pkg.sv]
// ----------------------------------------------------------------------------
// srfp_pkg
// Types and constants shared by the sensor reply frame parser.
// ----------------------------------------------------------------------------
package srfp_pkg;

  localparam logic [7:0] START_BYTE    = 8'hff;
  localparam logic [7:0] CMD_LEVEL     = 8'h86;
  localparam logic [7:0] CMD_ABC_OFF   = 8'h79;
  localparam logic [7:0] CMD_SET_RANGE = 8'h99;
  localparam logic [7:0] SUM_GOOD      = 8'hff;

  localparam logic [1:0] KIND_LEVEL     = 2'd0;
  localparam logic [1:0] KIND_ABC_OFF   = 2'd1;
  localparam logic [1:0] KIND_SET_RANGE = 2'd2;
  localparam logic [1:0] KIND_OTHER     = 2'd3;

  localparam logic [3:0] POS_HUNT  = 4'd1;
  localparam logic [3:0] POS_CMD   = 4'd2;
  localparam logic [3:0] POS_HIGH  = 4'd3;
  localparam logic [3:0] POS_LOW   = 4'd4;
  localparam logic [3:0] POS_PAD_A = 4'd5;
  localparam logic [3:0] POS_PAD_B = 4'd6;
  localparam logic [3:0] POS_PAD_C = 4'd7;
  localparam logic [3:0] POS_PAD_D = 4'd8;
  localparam logic [3:0] POS_SUM   = 4'd9;

  typedef struct packed {
    logic [1:0]  reply_kind;
    logic [15:0] level_ppm;
    logic        level_known;
  } reply_t;

  typedef struct packed {
    logic [3:0] pos;
    logic       level_seen;
  } status_t;

  function automatic logic [1:0] classify(input logic [7:0] c);
    logic [1:0] k;
    case (c)
      CMD_LEVEL:     k = KIND_LEVEL;
      CMD_ABC_OFF:   k = KIND_ABC_OFF;
      CMD_SET_RANGE: k = KIND_SET_RANGE;
      default:       k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

[design/srfp_if.sv]
// ----------------------------------------------------------------------------
// srfp channel interfaces
// Valid/ready channels for received bytes and for parsed replies.
// ----------------------------------------------------------------------------
interface srfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface srfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [15:0] level_ppm;
  logic        level_known;
  modport source (output valid, output reply_kind, output level_ppm, output level_known,
                  input ready);
  modport sink   (input valid, input reply_kind, input level_ppm, input level_known,
                  output ready);
endinterface

[design/srfp_step.sv]
// ----------------------------------------------------------------------------
// srfp_step
// Frame state registers and the per-byte update: position, checksum,
// command class and latched level.
// ----------------------------------------------------------------------------
module srfp_step import srfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output reply_t     res,
  output status_t    status
);

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  high_r, high_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] level_r, level_nxt;
  logic        seen_r, seen_nxt;
  logic [7:0]  sum_add;

  always_comb begin
    sum_add   = sum_r + rx_byte;
    pos_nxt   = pos_r;
    sum_nxt   = sum_add;
    high_nxt  = high_r;
    kind_nxt  = kind_r;
    level_nxt = level_r;
    seen_nxt  = seen_r;
    res_valid = 1'b0;
    case (pos_r)
      POS_CMD: begin
        kind_nxt = classify(rx_byte);
        pos_nxt  = POS_HIGH;
      end
      POS_HIGH: begin
        high_nxt = rx_byte;
        pos_nxt  = POS_LOW;
      end
      POS_LOW: begin
        if (kind_r == KIND_LEVEL) begin
          level_nxt = {high_r, rx_byte};
          seen_nxt  = 1'b1;
        end
        pos_nxt = POS_PAD_A;
      end
      POS_PAD_A, POS_PAD_B, POS_PAD_C, POS_PAD_D: begin
        pos_nxt = pos_r + 4'd1;
      end
      POS_SUM: begin
        pos_nxt   = POS_HUNT;
        res_valid = en && (sum_add == SUM_GOOD);
      end
      default: begin
        pos_nxt = POS_HUNT;
        if (rx_byte == START_BYTE) begin
          pos_nxt = POS_CMD;
          sum_nxt = START_BYTE;
        end
      end
    endcase
  end

  assign res.reply_kind  = kind_r;
  assign res.level_ppm   = level_r;
  assign res.level_known = seen_r;
  assign status.pos        = pos_r;
  assign status.level_seen = seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HUNT;
      sum_r   <= '0;
      high_r  <= '0;
      kind_r  <= KIND_LEVEL;
      level_r <= '0;
      seen_r  <= 1'b0;
    end else if (en) begin
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      high_r  <= high_nxt;
      kind_r  <= kind_nxt;
      level_r <= level_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

[design/sensor_reply_frame_parser.sv]
// ----------------------------------------------------------------------------
// sensor_reply_frame_parser
// Nine-byte reply frame parser with additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle unless reply back-pressure stalls it, and
// gives one reply for each nine-byte frame whose byte sum is 0xff; bad frames
// are dropped silently. A byte passes an input register and then the result
// register before its reply is presented. The frame state advances only as
// bytes leave the input register; back-pressure on the reply channel stalls
// the input once both registers are full.
module sensor_reply_frame_parser import srfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  srfp_in_if.sink    in_ch,
  srfp_out_if.source out_ch
);

  logic       in_v_r, in_v_nxt;
  logic [7:0] in_byte_r;
  logic       out_v_r, out_v_nxt;
  reply_t     out_res_r;
  logic       adv;
  logic       step_en;
  logic       res_valid;
  reply_t     res;
  status_t    status;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || adv;
  assign step_en     = in_v_r && adv;
  assign in_v_nxt    = in_ch.ready ? in_ch.valid : in_v_r;
  assign out_v_nxt   = adv ? (step_en && res_valid) : out_v_r;

  srfp_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (step_en),
    .rx_byte   (in_byte_r),
    .res_valid (res_valid),
    .res       (res),
    .status    (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.reply_kind  = out_res_r.reply_kind;
  assign out_ch.level_ppm   = out_res_r.level_ppm;
  assign out_ch.level_known = out_res_r.level_known;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (status.pos >= POS_HUNT) && (status.pos <= POS_SUM))
    else $error("frame position out of range");

  a_level_sticky: assert property (@(posedge clk)
    rst_n && $past(rst_n) && $past(status.level_seen) |-> status.level_seen)
    else $error("level seen flag cleared without reset");

  a_reply_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r && $stable(out_res_r))
    else $error("reply changed while stalled");

  a_level_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid && (res.reply_kind == KIND_LEVEL) |-> res.level_known)
    else $error("concentration reply without a latched level");

  a_reply_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && res_valid |-> status.pos == POS_SUM)
    else $error("reply outside the checksum byte");

endmodule

[tb/sensor_reply_frame_parser_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_reply_frame_parser_tb
// Self-checking bench for the nine-byte reply frame parser.
// ----------------------------------------------------------------------------
// Bytes are queued up front: a few hand-built frames, then mostly well-formed
// frames with random content, mixed with line noise and cut-short frames.
// A clocked driver feeds them with random gaps and runs a parser model on each
// accepted byte. A clocked monitor stalls replies at random and checks every
// reply against the oldest expected one.
module sensor_reply_frame_parser_tb;
  import srfp_pkg::*;

  localparam int BYTES_WANTED = 1400;
  localparam int STALL_LIMIT  = 1000;
  localparam int MAX_PRINTS   = 50;

  logic clk;
  logic rst_n;

  srfp_in_if  in_ch ();
  srfp_out_if out_ch ();

  sensor_reply_frame_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0] byte_queue[$];
  reply_t     replies_due[$];
  int         err_count = 0;
  int         idle_cycles;

  // parser model state
  logic [3:0]  frame_pos;
  logic [7:0]  byte_sum;
  logic [7:0]  msb_byte;
  logic [1:0]  cur_kind;
  logic [15:0] ppm_latch;
  logic        ppm_valid;

  int in_gap;
  int out_wait;
  bit in_calm;
  bit out_calm;

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
    err_count++;
  endtask

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic logic [1:0] kind_of(input logic [7:0] c);
    if (c == CMD_LEVEL) return KIND_LEVEL;
    if (c == CMD_ABC_OFF) return KIND_ABC_OFF;
    if (c == CMD_SET_RANGE) return KIND_SET_RANGE;
    return KIND_OTHER;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    reply_t r;
    byte_sum = byte_sum + b;
    case (frame_pos)
      POS_CMD: begin
        cur_kind  = kind_of(b);
        frame_pos = POS_HIGH;
      end
      POS_HIGH: begin
        msb_byte  = b;
        frame_pos = POS_LOW;
      end
      POS_LOW: begin
        if (cur_kind == KIND_LEVEL) begin
          ppm_latch = {msb_byte, b};
          ppm_valid = 1'b1;
        end
        frame_pos = POS_PAD_A;
      end
      POS_PAD_A, POS_PAD_B, POS_PAD_C, POS_PAD_D: begin
        frame_pos = frame_pos + 4'd1;
      end
      POS_SUM: begin
        frame_pos = POS_HUNT;
        if (byte_sum == SUM_GOOD) begin
          r.reply_kind  = cur_kind;
          r.level_ppm   = ppm_latch;
          r.level_known = ppm_valid;
          replies_due.push_back(r);
        end
      end
      default: begin
        frame_pos = POS_HUNT;
        if (b == START_BYTE) begin
          frame_pos = POS_CMD;
          byte_sum  = START_BYTE;
        end
      end
    endcase
  endtask

  // bytes two to nine of a frame must sum to zero for a good checksum
  task automatic add_frame(input logic [7:0] cmd, input logic [7:0] hi,
                           input logic [7:0] lo, input bit good);
    logic [7:0] acc;
    logic [7:0] pad;
    acc = cmd + hi + lo;
    byte_queue.push_back(START_BYTE);
    byte_queue.push_back(cmd);
    byte_queue.push_back(hi);
    byte_queue.push_back(lo);
    repeat (4) begin
      pad = $urandom_range(0, 255);
      acc = acc + pad;
      byte_queue.push_back(pad);
    end
    if (good) byte_queue.push_back(8'd0 - acc);
    else byte_queue.push_back(8'd0 - acc + 8'($urandom_range(1, 255)));
  endtask

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 3))
      0:       return CMD_LEVEL;
      1:       return CMD_ABC_OFF;
      2:       return CMD_SET_RANGE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.rx_byte <= '0;
      in_gap        <= draw_wait(1'b0);
      in_calm       = 1'b0;
      frame_pos     = POS_HUNT;
      byte_sum      = '0;
      msb_byte      = '0;
      cur_kind      = KIND_LEVEL;
      ppm_latch     = '0;
      ppm_valid     = 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid) parse_byte(in_ch.rx_byte);
      if (in_gap != 0 || byte_queue.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap != 0) in_gap <= in_gap - 1;
      end else begin
        in_ch.valid   <= 1'b1;
        in_ch.rx_byte <= byte_queue.pop_front();
        if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
        in_gap <= draw_wait(in_calm);
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    reply_t want;
    int     nxt;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait     <= draw_wait(1'b0);
      out_calm     = 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with none expected");
        end else begin
          want = replies_due.pop_front();
          if (out_ch.reply_kind !== want.reply_kind)
            report_mismatch($sformatf("reply_kind %0d, expected %0d",
                                      out_ch.reply_kind, want.reply_kind));
          if (out_ch.level_ppm !== want.level_ppm)
            report_mismatch($sformatf("level_ppm %0d, expected %0d",
                                      out_ch.level_ppm, want.level_ppm));
          if (out_ch.level_known !== want.level_known)
            report_mismatch($sformatf("level_known %0b, expected %0b",
                                      out_ch.level_known, want.level_known));
        end
        if ($urandom_range(0, 9) == 0) out_calm = !out_calm;
        nxt = draw_wait(out_calm);
        out_wait     <= nxt;
        out_ch.ready <= (nxt == 0);
      end else if (out_wait != 0) begin
        out_wait     <= out_wait - 1;
        out_ch.ready <= (out_wait == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int k;
    rst_n = 1'b0;

    // noise, then a good ack before any level (start byte as byte three),
    // a level frame with a bad checksum, then a good ack showing it latched
    byte_queue.push_back(8'h00);
    add_frame(CMD_ABC_OFF, START_BYTE, 8'h00, 1'b1);
    add_frame(CMD_LEVEL, 8'hff, 8'hff, 1'b0);
    add_frame(CMD_SET_RANGE, 8'h00, 8'h00, 1'b1);

    while (byte_queue.size() < BYTES_WANTED) begin
      k = $urandom_range(0, 99);
      if (k < 75) begin
        add_frame(pick_cmd(), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 9) < 8);
      end else if (k < 90) begin
        repeat ($urandom_range(1, 4)) byte_queue.push_back(8'($urandom_range(0, 255)));
      end else begin
        // cut-short frame; the next start byte lands inside it
        byte_queue.push_back(START_BYTE);
        byte_queue.push_back(pick_cmd());
        repeat ($urandom_range(0, 6)) byte_queue.push_back(8'($urandom_range(0, 255)));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (err_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
design/srfp_pkg.sv
design/srfp_if.sv
design/srfp_step.sv
design/sensor_reply_frame_parser.sv
tb/sensor_reply_frame_parser_tb.sv
